// File: design/triangle_face_normal_defines.svh
// assertion macros for the triangle face normal block
`ifndef TRIANGLE_FACE_NORMAL_DEFINES_SVH
`define TRIANGLE_FACE_NORMAL_DEFINES_SVH
`ifndef SYNTHESIS
`define TFN_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define TFN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define TFN_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define TFN_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: design/tfn_pkg.sv
// shared types and widths for the triangle face normal block
`default_nettype none
package tfn_pkg;
    localparam int EDGE_W     = 17;
    localparam int PROD_W     = 34;
    localparam int CR_W       = 35;
    localparam int MAG_W      = 34;
    localparam int SM_W       = 31;
    localparam int SQ_W       = 62;
    localparam int SUM_W      = 64;
    localparam int ROOT_W     = 32;
    localparam int REM_W      = 35;
    localparam int NUM_W      = 46;
    localparam int Q_W        = 15;
    localparam int FRAC_SH    = 14;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 15;
    localparam int NORM_LO    = 30;
    localparam int V_SUM      = 6;
    localparam int V_NUM      = V_SUM + SQRT_STEPS + 1;
    localparam int NSTG       = V_NUM + DIV_STEPS + 2;
    localparam logic [Q_W-1:0] Q_ONE = Q_W'(1 << FRAC_SH);

    typedef struct packed {
        logic signed [15:0] a_x;
        logic signed [15:0] a_y;
        logic signed [15:0] a_z;
        logic signed [15:0] b_x;
        logic signed [15:0] b_y;
        logic signed [15:0] b_z;
        logic signed [15:0] c_x;
        logic signed [15:0] c_y;
        logic signed [15:0] c_z;
    } t_tri_in;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic               degenerate;
    } t_norm_out;

    typedef struct packed {
        logic [2:0][SM_W-1:0] mag;
        logic [2:0]           neg;
        logic                 degen;
    } t_carry;
endpackage
`default_nettype wire

// File: design/triangle_face_normal.sv
// triangle face normal: edge cross product normalized to unit length
//
// input channel i_in_valid / o_in_ready carries one triangle (three corners,
// signed q2.13) per item; output channel o_out_valid / i_out_ready returns
// the unit normal in signed q1.14 plus a degenerate flag
// one item may enter every cycle while the skid register is empty;
// throughput is one item per cycle as long as the receiver does not stall
// an accepted item runs through 56 pipeline stages plus the output register
// the depth is set by the square root (one result bit per stage, 32 stages)
// and the three dividers (one quotient bit per stage, 15 stages)
// a zero cross product gives a zero normal with degenerate set
// reset clears all valid bits; payload registers are not reset
// when the receiver stalls, a skid register catches the item in flight and
// the whole pipeline then holds; nothing is lost or repeated
`default_nettype none
`include "triangle_face_normal_defines.svh"
module triangle_face_normal import tfn_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_tri_in   i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_norm_out      o_out_data
);
    // pipeline advance, held while the skid register is full
    logic en;
    logic in_acc;
    logic [NSTG-1:0] r_v;

    // stage 1: edges
    logic signed [EDGE_W-1:0] r_s1_d0 [3];
    logic signed [EDGE_W-1:0] r_s1_d1 [3];
    // stage 2: six products
    logic signed [PROD_W-1:0] r_s2_p [6];
    // stage 3: cross product magnitudes and signs
    logic signed [CR_W-1:0] cr [3];
    logic [MAG_W-1:0] r_s3_mag [3];
    logic [2:0] r_s3_neg;
    // stage 4: block scaling amount
    logic [MAG_W-1:0] m01, mmax;
    logic [5:0] hb;
    logic [MAG_W-1:0] r_s4_mag [3];
    logic [2:0] r_s4_neg;
    logic r_s4_degen, r_s4_left;
    logic [4:0] r_s4_shl;
    logic [1:0] r_s4_shr;
    // stage 5: scaled magnitudes
    logic [SM_W-1:0] r_s5_mag [3];
    logic [2:0] r_s5_neg;
    logic r_s5_degen;
    // stage 6: squares
    logic [SQ_W-1:0] r_s6_sq [3];
    t_carry r_s6_c;
    // square root pipe, index 0 is the sum of squares
    logic [SUM_W-1:0]  r_sq_s    [0:SQRT_STEPS-1];
    logic [REM_W-1:0]  r_sq_rem  [0:SQRT_STEPS-1];
    logic [ROOT_W-1:0] r_sq_root [0:SQRT_STEPS];
    t_carry            r_sq_c    [0:SQRT_STEPS];
    // divider pipe, index 0 holds the rounded numerators
    logic [NUM_W-1:0]  r_dv_r     [0:DIV_STEPS-1][3];
    logic [Q_W-1:0]    r_dv_q     [0:DIV_STEPS][3];
    logic [ROOT_W-1:0] r_dv_l     [0:DIV_STEPS-1];
    logic [2:0]        r_dv_neg   [0:DIV_STEPS];
    logic              r_dv_degen [0:DIV_STEPS];
    // tail and output side
    t_norm_out r_tail;
    t_norm_out r_skid;
    logic r_skid_v;
    t_norm_out r_out;
    logic r_out_v;
    logic out_zero;

    assign en = !r_skid_v;
    assign o_in_ready = en;
    assign in_acc = i_in_valid && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (en) begin
            r_v <= {r_v[NSTG-2:0], in_acc};
        end
    end

    // edges d0 = a - b, d1 = c - b
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_d0[0] <= EDGE_W'(i_in_data.a_x) - EDGE_W'(i_in_data.b_x);
            r_s1_d0[1] <= EDGE_W'(i_in_data.a_y) - EDGE_W'(i_in_data.b_y);
            r_s1_d0[2] <= EDGE_W'(i_in_data.a_z) - EDGE_W'(i_in_data.b_z);
            r_s1_d1[0] <= EDGE_W'(i_in_data.c_x) - EDGE_W'(i_in_data.b_x);
            r_s1_d1[1] <= EDGE_W'(i_in_data.c_y) - EDGE_W'(i_in_data.b_y);
            r_s1_d1[2] <= EDGE_W'(i_in_data.c_z) - EDGE_W'(i_in_data.b_z);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_p[0] <= r_s1_d1[1] * r_s1_d0[2];
            r_s2_p[1] <= r_s1_d1[2] * r_s1_d0[1];
            r_s2_p[2] <= r_s1_d1[2] * r_s1_d0[0];
            r_s2_p[3] <= r_s1_d1[0] * r_s1_d0[2];
            r_s2_p[4] <= r_s1_d1[0] * r_s1_d0[1];
            r_s2_p[5] <= r_s1_d1[1] * r_s1_d0[0];
        end
    end

    // cross product d1 x d0, split into sign and magnitude
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            cr[i] = CR_W'(r_s2_p[2*i]) - CR_W'(r_s2_p[2*i+1]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_s3_neg[i] <= cr[i][CR_W-1];
                r_s3_mag[i] <= cr[i][CR_W-1] ? MAG_W'(-cr[i]) : MAG_W'(cr[i]);
            end
        end
    end

    // largest magnitude and its top bit decide the block shift
    always_comb begin
        m01  = (r_s3_mag[0] > r_s3_mag[1]) ? r_s3_mag[0] : r_s3_mag[1];
        mmax = (m01 > r_s3_mag[2]) ? m01 : r_s3_mag[2];
        hb   = '0;
        for (int b = 0; b < MAG_W; b++) begin
            if (mmax[b]) hb = 6'(b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s4_mag   <= r_s3_mag;
            r_s4_neg   <= r_s3_neg;
            r_s4_degen <= (mmax == '0);
            r_s4_left  <= (hb < 6'(NORM_LO));
            r_s4_shl   <= 5'(6'(NORM_LO) - hb);
            r_s4_shr   <= 2'(hb - 6'(NORM_LO));
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_s5_mag[i] <= r_s4_left ? SM_W'(r_s4_mag[i] << r_s4_shl)
                                         : SM_W'(r_s4_mag[i] >> r_s4_shr);
            end
            r_s5_neg   <= r_s4_neg;
            r_s5_degen <= r_s4_degen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_s6_sq[i]    <= SQ_W'(r_s5_mag[i]) * SQ_W'(r_s5_mag[i]);
                r_s6_c.mag[i] <= r_s5_mag[i];
            end
            r_s6_c.neg   <= r_s5_neg;
            r_s6_c.degen <= r_s5_degen;
        end
    end

    // sum of squares seeds the square root pipe
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sq_s[0]    <= SUM_W'(r_s6_sq[0]) + SUM_W'(r_s6_sq[1]) + SUM_W'(r_s6_sq[2]);
            r_sq_rem[0]  <= '0;
            r_sq_root[0] <= '0;
            r_sq_c[0]    <= r_s6_c;
        end
    end

    // digit-by-digit integer square root, one root bit per stage
    always_ff @(posedge i_clk) begin
        logic [REM_W-1:0] remsh;
        logic [REM_W-1:0] trial;
        if (en) begin
            for (int k = 0; k < SQRT_STEPS; k++) begin
                remsh = {r_sq_rem[k][REM_W-3:0], r_sq_s[k][SUM_W-1-2*k -: 2]};
                trial = REM_W'({r_sq_root[k], 2'b01});
                if (remsh >= trial) begin
                    if (k + 1 < SQRT_STEPS) r_sq_rem[k+1] <= remsh - trial;
                    r_sq_root[k+1] <= {r_sq_root[k][ROOT_W-2:0], 1'b1};
                end else begin
                    if (k + 1 < SQRT_STEPS) r_sq_rem[k+1] <= remsh;
                    r_sq_root[k+1] <= {r_sq_root[k][ROOT_W-2:0], 1'b0};
                end
                if (k + 1 < SQRT_STEPS) r_sq_s[k+1] <= r_sq_s[k];
                r_sq_c[k+1] <= r_sq_c[k];
            end
        end
    end

    // numerators mag * 2^14 + floor(len / 2), rounding half up
    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_dv_r[0][i] <= (NUM_W'(r_sq_c[SQRT_STEPS].mag[i]) << FRAC_SH)
                              + NUM_W'(r_sq_root[SQRT_STEPS] >> 1);
                r_dv_q[0][i] <= '0;
            end
            r_dv_l[0]     <= r_sq_root[SQRT_STEPS];
            r_dv_neg[0]   <= r_sq_c[SQRT_STEPS].neg;
            r_dv_degen[0] <= r_sq_c[SQRT_STEPS].degen;
        end
    end

    // restoring division, one quotient bit per stage, msb first
    always_ff @(posedge i_clk) begin
        logic [NUM_W-1:0] dsh;
        if (en) begin
            for (int j = 0; j < DIV_STEPS; j++) begin
                dsh = NUM_W'(r_dv_l[j]) << (DIV_STEPS - 1 - j);
                for (int i = 0; i < 3; i++) begin
                    if (r_dv_r[j][i] >= dsh) begin
                        if (j + 1 < DIV_STEPS) r_dv_r[j+1][i] <= r_dv_r[j][i] - dsh;
                        r_dv_q[j+1][i] <= r_dv_q[j][i] | (Q_W'(1) << (DIV_STEPS - 1 - j));
                    end else begin
                        if (j + 1 < DIV_STEPS) r_dv_r[j+1][i] <= r_dv_r[j][i];
                        r_dv_q[j+1][i] <= r_dv_q[j][i];
                    end
                end
                if (j + 1 < DIV_STEPS) r_dv_l[j+1] <= r_dv_l[j];
                r_dv_neg[j+1]   <= r_dv_neg[j];
                r_dv_degen[j+1] <= r_dv_degen[j];
            end
        end
    end

    // clamp, apply sign, force zero for a degenerate triangle
    always_ff @(posedge i_clk) begin
        logic [Q_W-1:0]    q;
        logic signed [15:0] n [3];
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                q = (r_dv_q[DIV_STEPS][i] > Q_ONE) ? Q_ONE : r_dv_q[DIV_STEPS][i];
                n[i] = r_dv_neg[DIV_STEPS][i] ? -16'({1'b0, q}) : 16'({1'b0, q});
                if (r_dv_degen[DIV_STEPS]) n[i] = '0;
            end
            r_tail.normal_x   <= n[0];
            r_tail.normal_y   <= n[1];
            r_tail.normal_z   <= n[2];
            r_tail.degenerate <= r_dv_degen[DIV_STEPS];
        end
    end

    // output register with a skid stage behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (!r_out_v || i_out_ready) begin
            r_out_v  <= r_skid_v || r_v[NSTG-1];
            r_skid_v <= 1'b0;
        end else if (r_v[NSTG-1] && en) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_v || i_out_ready) begin
            r_out <= r_skid_v ? r_skid : r_tail;
        end else if (r_v[NSTG-1] && en) begin
            r_skid <= r_tail;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    // all three normal components zero
    assign out_zero = (o_out_data.normal_x == '0) && (o_out_data.normal_y == '0)
                   && (o_out_data.normal_z == '0);

    `TFN_ASSERT_IMPLY(a_skid_behind_out, i_clk, i_rst_n, r_skid_v, r_out_v)
    `TFN_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, in_acc, r_v[0])
    `TFN_ASSERT_IMPLY(a_degen_zero, i_clk, i_rst_n, o_out_valid && o_out_data.degenerate, out_zero)
    `TFN_ASSERT_IMPLY(a_normal_nonzero, i_clk, i_rst_n, o_out_valid && !o_out_data.degenerate, !out_zero)
endmodule
`default_nettype wire
